>>> design/imm_pkg.sv
package imm_pkg;

   localparam logic [1:0] CMD_LOAD_A  = 2'd0;
   localparam logic [1:0] CMD_LOAD_B  = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [3:0]         row;
      logic [3:0]         col;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [3:0]  out_row;
      logic [3:0]  out_col;
      logic [63:0] product_sum;
      logic        last;
   } rsp_type;

   // One element of the A row travelling down the cell chain.
   typedef struct packed {
      logic               valid;
      logic               first;
      logic               last;
      logic signed [31:0] a;
   } token_type;

endpackage

>>> design/integer_matrix_multiply_unit.sv
// Integer matrix multiply unit, C = A x B with DIM x DIM signed 32-bit operands.
// Input channel req_*: an item loads one element of A (cmd 0) or B (cmd 1) at
// (row, col), or asks for row "row" of C (cmd 2). Loads give no result; unused
// codes and out-of-range indices are dropped.
// Result channel rsp_*: a compute item yields DIM items, columns in order, each
// the 64-bit wrapped dot product, with last set on the final column.
// A row of DIM cells each holds one column of B and an accumulator. The A row
// is read one element a cycle and shifts along the cells. When the last cell
// is done, the results leave one per cycle while rsp_stall is low.
// While a compute item is in progress req_stall is high. A stalled result
// holds its value until taken. Reset returns the control to idle; the stored
// matrices are not cleared and must be written before they are used.
module integer_matrix_multiply_unit #(
   parameter int DIM = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  imm_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output imm_pkg::rsp_type rsp_item
);
   import imm_pkg::*;

   localparam int KW = $clog2(DIM);
   localparam int AW = 2 * KW;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_FEED  = 4'b0010,
      S_WAIT  = 4'b0100,
      S_DRAIN = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   logic [KW-1:0] k_ff, k_in;
   logic [KW-1:0] row_idx_ff, row_idx_in;
   logic [3:0]    row_ff, row_in;
   logic          feed_vld_ff, feed_first_ff, feed_last_ff;
   logic          req_take, rsp_take, in_range;
   logic          a_we, b_ld;
   logic [KW-1:0] req_row, req_col;
   logic [31:0]   a_rdata;
   logic          chain_done;

   token_type     tok [DIM];
   logic [63:0]   sums [DIM+1];

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign req_row  = KW'(req_item.row);
   assign req_col  = KW'(req_item.col);
   assign in_range = (32'(req_item.row) < DIM) && (32'(req_item.col) < DIM);
   assign a_we     = req_take && req_item.cmd == CMD_LOAD_A && in_range;
   assign b_ld     = req_take && req_item.cmd == CMD_LOAD_B && in_range;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DRAIN);

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      row_idx_in = row_idx_ff;
      row_in     = row_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take && req_item.cmd == CMD_COMPUTE && 32'(req_item.row) < DIM) begin
               state_in   = S_FEED;
               k_in       = '0;
               row_idx_in = req_row;
               row_in     = req_item.row;
            end
         end
         S_FEED: begin
            k_in = KW'(k_ff + 1'b1);
            if (k_ff == KW'(DIM - 1)) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (chain_done) begin
               state_in = S_DRAIN;
               k_in     = '0;
            end
         end
         S_DRAIN: begin
            if (rsp_take) begin
               k_in = KW'(k_ff + 1'b1);
               if (k_ff == KW'(DIM - 1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         k_ff        <= '0;
         feed_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         k_ff        <= k_in;
         feed_vld_ff <= (state_ff == S_FEED);
      end
      row_idx_ff    <= row_idx_in;
      row_ff        <= row_in;
      feed_first_ff <= (k_ff == '0);
      feed_last_ff  <= (k_ff == KW'(DIM - 1));
   end

   // The store is addressed by {row, column}, so it spans the full index space.
   imm_ram #(.WIDTH(32), .DEPTH(2 ** AW)) u_a_store (
      .clock      (clock),
      .wr_en      (a_we),
      .wr_addr    ({req_row, req_col}),
      .wr_data    (req_item.value),
      .rd_addr    (AW'({row_idx_ff, k_ff})),
      .rd_data_ff (a_rdata)
   );

   assign tok[0].valid = feed_vld_ff;
   assign tok[0].first = feed_first_ff;
   assign tok[0].last  = feed_last_ff;
   assign tok[0].a     = a_rdata;
   assign sums[DIM]    = '0;

   for (genvar j = 0; j < DIM; j++) begin : g_cell
      if (j < DIM - 1) begin : g_mid
         imm_cell #(.DIM(DIM)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .tok_in   (tok[j]),
            .tok_out  (tok[j+1]),
            .b_we     (b_ld && req_col == KW'(j)),
            .b_waddr  (req_row),
            .b_wdata  (req_item.value),
            .shift_en (rsp_take),
            .sum_in   (sums[j+1]),
            .sum_out  (sums[j]),
            .done     ()
         );
      end else begin : g_end
         imm_cell #(.DIM(DIM)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .tok_in   (tok[j]),
            .tok_out  (),
            .b_we     (b_ld && req_col == KW'(j)),
            .b_waddr  (req_row),
            .b_wdata  (req_item.value),
            .shift_en (rsp_take),
            .sum_in   (sums[j+1]),
            .sum_out  (sums[j]),
            .done     (chain_done)
         );
      end
   end

   // Results leave from the first cell; the chain shifts toward it on each take.
   assign rsp_item.out_row     = row_ff;
   assign rsp_item.out_col     = 4'(k_ff);
   assign rsp_item.product_sum = sums[0];
   assign rsp_item.last        = (k_ff == KW'(DIM - 1));

endmodule

>>> design/imm_ram.sv
module imm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

>>> design/imm_cell.sv
module imm_cell #(
   parameter int DIM = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  imm_pkg::token_type          tok_in,
   output imm_pkg::token_type          tok_out,
   input  logic                        b_we,
   input  logic [$clog2(DIM)-1:0]      b_waddr,
   input  logic [31:0]                 b_wdata,
   input  logic                        shift_en,
   input  logic [63:0]                 sum_in,
   output logic [63:0]                 sum_out,
   output logic                        done
);
   import imm_pkg::*;

   localparam int KW = $clog2(DIM);

   token_type          tok_ff;
   logic [KW-1:0]      k_ff;
   logic [KW-1:0]      rd_addr;
   logic [31:0]        b_rdata;
   logic signed [63:0] prod_ff;
   logic               prod_vld_ff;
   logic               prod_first_ff;
   logic               prod_last_ff;
   logic [63:0]        acc_ff;
   logic               done_ff;

   // The cell walks its own column of B in step with the arriving A elements.
   assign rd_addr = tok_in.first ? '0 : KW'(k_ff + 1'b1);

   imm_ram #(.WIDTH(32), .DEPTH(DIM)) u_b_col (
      .clock      (clock),
      .wr_en      (b_we),
      .wr_addr    (b_waddr),
      .wr_data    (b_wdata),
      .rd_addr    (rd_addr),
      .rd_data_ff (b_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         prod_vld_ff  <= 1'b0;
         done_ff      <= 1'b0;
         k_ff         <= '0;
      end else begin
         tok_ff.valid <= tok_in.valid;
         prod_vld_ff  <= tok_ff.valid;
         done_ff      <= prod_vld_ff && prod_last_ff;
         if (tok_in.valid) begin
            k_ff <= rd_addr;
         end
      end
      tok_ff.first  <= tok_in.first;
      tok_ff.last   <= tok_in.last;
      tok_ff.a      <= tok_in.a;
      prod_ff       <= tok_ff.a * $signed(b_rdata);
      prod_first_ff <= tok_ff.first;
      prod_last_ff  <= tok_ff.last;
      if (prod_vld_ff) begin
         acc_ff <= prod_first_ff ? 64'(prod_ff) : acc_ff + 64'(prod_ff);
      end else if (shift_en) begin
         acc_ff <= sum_in;
      end
   end

   assign tok_out = tok_ff;
   assign sum_out = acc_ff;
   assign done    = done_ff;

endmodule

>>> tb/integer_matrix_multiply_checker.sv
module integer_matrix_multiply_checker #(
   parameter int DIM = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  imm_pkg::req_type req_item,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  imm_pkg::rsp_type rsp_item,
   output int               fail_count,
   output int               pending_count,
   output int               rows_checked
);
   import imm_pkg::*;

   logic signed [31:0] a_matrix [DIM*DIM];
   logic signed [31:0] b_matrix [DIM*DIM];
   rsp_type            expected_elements [$];
   int                 mismatch_count;

   function automatic logic [63:0] row_column_dot(int i, int j);
      logic [63:0]        acc;
      logic signed [63:0] term;
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
         term = 64'(a_matrix[i*DIM+k]) * 64'(b_matrix[k*DIM+j]);
         acc  = acc + term;
      end
      return acc;
   endfunction

   task automatic apply_request(input req_type r);
      rsp_type e;
      if ((r.cmd == CMD_LOAD_A || r.cmd == CMD_LOAD_B) && r.row < DIM && r.col < DIM) begin
         if (r.cmd == CMD_LOAD_A) a_matrix[r.row*DIM + r.col] = r.value;
         else                     b_matrix[r.row*DIM + r.col] = r.value;
      end else if (r.cmd == CMD_COMPUTE && r.row < DIM) begin
         for (int j = 0; j < DIM; j++) begin
            e.out_row     = 4'(r.row);
            e.out_col     = 4'(j);
            e.product_sum = row_column_dot(r.row, j);
            e.last        = (j == DIM - 1);
            expected_elements.push_back(e);
         end
      end
   endtask

   task automatic note_mismatch(input string what, input rsp_type exp_e, input rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch (%s): expected row %0d col %0d sum %h last %b, %s",
                  what, exp_e.out_row, exp_e.out_col, exp_e.product_sum, exp_e.last,
                  $sformatf("got row %0d col %0d sum %h last %b",
                            got.out_row, got.out_col, got.product_sum, got.last));
   endtask

   always @(posedge clock) begin
      rsp_type exp_e;
      if (reset) begin
         expected_elements.delete();
      end else begin
         if (req_valid && !req_stall) apply_request(req_item);
         if (rsp_valid && !rsp_stall) begin
            if (expected_elements.size() == 0) begin
               exp_e = '0;
               note_mismatch("unexpected item", exp_e, rsp_item);
            end else begin
               exp_e = expected_elements.pop_front();
               if (rsp_item !== exp_e) note_mismatch("field", exp_e, rsp_item);
               if (exp_e.last) rows_checked++;
            end
         end
      end
      pending_count = expected_elements.size();
   end

   initial begin
      mismatch_count = 0;
      rows_checked   = 0;
      pending_count  = 0;
   end

   assign fail_count    = mismatch_count;
endmodule

>>> tb/tb_integer_matrix_multiply_unit.sv
module tb_integer_matrix_multiply_unit;
   import imm_pkg::*;

   localparam int DIM           = 16;
   localparam int WATCHDOG_MAX  = 20000;
   localparam int DRAIN_CYCLES  = 4*DIM + 20;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;
   int      fail_count, pending_count, rows_checked;
   int      idle_cycles = 0;
   int      items_sent = 0;
   bit      steady = 1'b0;
   bit      a_written [DIM*DIM];
   bit      b_written [DIM*DIM];

   integer_matrix_multiply_unit #(.DIM(DIM)) dut (.*);

   integer_matrix_multiply_checker #(.DIM(DIM)) monitor (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The result side stalls at random except during the steady stretch.
   always @(posedge clock)
      rsp_stall <= !steady && ($urandom_range(99) < 35);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("watchdog expired, %0d elements still expected", pending_count);
         $display("FAIL integer_matrix_multiply_unit");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] cmd, input int row, input int col,
                            input logic [31:0] value);
      while (!steady && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_item.cmd   <= cmd;
      req_item.row   <= 4'(row);
      req_item.col   <= 4'(col);
      req_item.value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_valid <= 1'b0;
      items_sent++;
      if ((cmd == CMD_LOAD_A || cmd == CMD_LOAD_B) && row < DIM && col < DIM) begin
         if (cmd == CMD_LOAD_A) a_written[row*DIM+col] = 1'b1;
         else                   b_written[row*DIM+col] = 1'b1;
      end
   endtask

   function automatic logic [31:0] random_element();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'(int'($urandom_range(20)) - 10);
         default: return $urandom;
      endcase
   endfunction

   // A compute is issued only for a row whose A row and every B entry are loaded.
   function automatic bit row_ready(int row);
      for (int k = 0; k < DIM; k++) begin
         if (!a_written[row*DIM+k]) return 1'b0;
         for (int j = 0; j < DIM; j++) if (!b_written[k*DIM+j]) return 1'b0;
      end
      return 1'b1;
   endfunction

   initial begin
      int row;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill both matrices, the most negative value on the whole diagonal.
      for (int r = 0; r < DIM; r++)
         for (int c = 0; c < DIM; c++) begin
            send_item(CMD_LOAD_A, r, c, (r == c) ? 32'h8000_0000 : random_element());
            send_item(CMD_LOAD_B, r, c, (r == c) ? 32'h8000_0000 : random_element());
         end
      send_item(CMD_COMPUTE, 0, 15, 32'hffff_ffff);
      send_item(CMD_COMPUTE, DIM - 1, 0, 32'h0);
      send_item(CMD_UNUSED, 5, 5, 32'h1234_5678);
      send_item(CMD_LOAD_A, 3, 3, 32'h7fff_ffff);
      send_item(CMD_LOAD_B, 3, 3, 32'h7fff_ffff);
      send_item(CMD_COMPUTE, 3, 7, 32'h5555_aaaa);

      // Mixed random traffic with a steady stretch in the middle.
      for (int n = 0; n < 200; n++) begin
         steady = (n >= 80 && n < 120);
         row = $urandom_range(DIM - 1);
         case ($urandom_range(9))
            0, 1, 2, 3: send_item(CMD_LOAD_A, row, $urandom_range(15), random_element());
            4, 5, 6:    send_item(CMD_LOAD_B, row, $urandom_range(15), random_element());
            7, 8:       if (row_ready(row)) send_item(CMD_COMPUTE, row, $urandom_range(15), $urandom);
            default:    send_item(CMD_UNUSED, $urandom_range(15), $urandom_range(15), $urandom);
         endcase
      end
      steady = 1'b0;

      // Let the checker see the last accepted item before looking at its backlog.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d request items sent, %0d result rows of C checked", items_sent, rows_checked);
      if (fail_count == 0 && pending_count == 0) $display("PASS integer_matrix_multiply_unit");
      else $display("FAIL integer_matrix_multiply_unit");
      $finish;
   end
endmodule
